### rtl/uat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uat_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DEPTH_MAX     = 1024;
   // wide enough for any index or count up to DEPTH_MAX
   localparam int CNT_W         = $clog2(DEPTH_MAX + 1);

   typedef enum logic [2:0] {
      CMD_INSERT  = 3'd0,
      CMD_DELETE  = 3'd1,
      CMD_REPLACE = 3'd2,
      CMD_READ    = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'd0,
      FSM_SWEEP = 2'd1,
      FSM_OUT   = 2'd2
   } fsm_type;

   // request token that walks the cell row
   typedef struct packed {
      logic               valid;
      cmd_type            cmd;
      logic signed [31:0] value;
      logic signed [31:0] new_value;
      logic [CNT_W-1:0]   target;
      logic [CNT_W-1:0]   used;
      logic               found;
      logic [CNT_W-1:0]   pos;
      logic [CNT_W-1:0]   count;
      logic signed [31:0] rdata;
   } token_type;

   typedef struct packed {
      status_type         status;
      logic [CNT_W-1:0]   pos;
      logic [CNT_W-1:0]   used;
      logic signed [31:0] rdata;
      logic [CNT_W-1:0]   count;
   } result_type;

endpackage

`default_nettype wire

### rtl/uat_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module uat_cell #(
   parameter int INDEX = 0
) (
   input  wire                 clock,
   input  wire                 reset,
   input  uat_pkg::token_type  tok_in,
   output uat_pkg::token_type  tok_out,
   input  wire signed [31:0]   next_entry,
   input  wire                 next_shift,
   output logic signed [31:0]  entry_out,
   output logic                shift_out
);

   localparam logic [uat_pkg::CNT_W-1:0] IDX = uat_pkg::CNT_W'(INDEX);

   logic signed [31:0] entry_ff, entry_in;
   uat_pkg::token_type tok_ff, tok_in_d;
   logic in_use, hit;

   always_comb begin
      tok_in_d  = tok_in;
      entry_in  = entry_ff;
      shift_out = 1'b0;
      in_use    = IDX < tok_in.used;
      hit       = in_use && (entry_ff == tok_in.value);
      if (tok_in.valid) begin
         case (tok_in.cmd)
            uat_pkg::CMD_INSERT: begin
               if (IDX == tok_in.target) entry_in = tok_in.value;
            end
            uat_pkg::CMD_DELETE: begin
               // past the removed entry: hand this entry down one place
               if (tok_in.found && in_use) begin
                  shift_out = 1'b1;
               end else if (hit) begin
                  tok_in_d.found = 1'b1;
                  tok_in_d.pos   = IDX;
               end
            end
            uat_pkg::CMD_REPLACE: begin
               if (hit) begin
                  entry_in       = tok_in.new_value;
                  tok_in_d.count = tok_in.count + uat_pkg::CNT_W'(1);
               end
            end
            uat_pkg::CMD_READ: begin
               if (IDX == tok_in.target) tok_in_d.rdata = entry_ff;
            end
            default: begin
            end
         endcase
      end
      if (next_shift) entry_in = next_entry;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_d;
      end
   end

   assign tok_out   = tok_ff;
   assign entry_out = entry_ff;

endmodule

`default_nettype wire

### rtl/uat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module uat_ctrl #(
   parameter int DEPTH = uat_pkg::DEPTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [2:0]          req_cmd,
   input  wire  signed [31:0]  req_value,
   input  wire  signed [31:0]  req_new_value,
   input  wire  [5:0]          req_read_index,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [5:0]          rsp_position,
   output logic [6:0]          rsp_used_count,
   output logic signed [31:0]  rsp_read_data,
   output logic [6:0]          rsp_replaced,
   input  wire                 csr_wr_en,
   input  wire  [6:0]          csr_wr_data,
   output uat_pkg::token_type  launch_tok,
   input  uat_pkg::token_type  done_tok
);

   localparam int CW = uat_pkg::CNT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   uat_pkg::fsm_type    state_ff, state_in;
   uat_pkg::token_type  launch_ff, launch_in;
   uat_pkg::result_type res_ff, res_in, rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]       used_ff, used_in;
   logic [6:0]          capacity_ff;
   logic [CW-1:0]       cap_ext, eff_cap, ridx_ext;

   always_comb begin
      cap_ext  = CW'(capacity_ff);
      eff_cap  = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
      ridx_ext = CW'(req_read_index);

      state_in     = state_ff;
      launch_in    = launch_ff;
      launch_in.valid = 1'b0;
      res_in       = res_ff;
      used_in      = used_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = state_ff != uat_pkg::FSM_IDLE;

      case (state_ff)
         uat_pkg::FSM_IDLE: begin
            if (req_valid) begin
               launch_in.cmd       = uat_pkg::cmd_type'(req_cmd);
               launch_in.value     = req_value;
               launch_in.new_value = req_new_value;
               launch_in.target    = '0;
               launch_in.used      = used_ff;
               launch_in.found     = 1'b0;
               launch_in.pos       = '0;
               launch_in.count     = '0;
               launch_in.rdata     = '0;
               res_in.status = uat_pkg::ST_OK;
               res_in.pos    = '0;
               res_in.used   = used_ff;
               res_in.rdata  = '0;
               res_in.count  = '0;
               state_in      = uat_pkg::FSM_OUT;
               case (uat_pkg::cmd_type'(req_cmd))
                  uat_pkg::CMD_INSERT: begin
                     if (used_ff < eff_cap) begin
                        launch_in.valid  = 1'b1;
                        launch_in.target = used_ff;
                        state_in         = uat_pkg::FSM_SWEEP;
                     end else begin
                        res_in.status = uat_pkg::ST_FULL;
                     end
                  end
                  uat_pkg::CMD_DELETE, uat_pkg::CMD_REPLACE: begin
                     launch_in.valid = 1'b1;
                     state_in        = uat_pkg::FSM_SWEEP;
                  end
                  uat_pkg::CMD_READ: begin
                     if (ridx_ext < used_ff) begin
                        launch_in.valid  = 1'b1;
                        launch_in.target = ridx_ext;
                        state_in         = uat_pkg::FSM_SWEEP;
                     end else begin
                        res_in.status = uat_pkg::ST_BAD_INDEX;
                     end
                  end
                  uat_pkg::CMD_CLEAR: begin
                     used_in     = '0;
                     res_in.used = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         uat_pkg::FSM_SWEEP: begin
            if (done_tok.valid) begin
               res_in.status = uat_pkg::ST_OK;
               res_in.pos    = '0;
               res_in.used   = done_tok.used;
               res_in.rdata  = '0;
               res_in.count  = '0;
               case (done_tok.cmd)
                  uat_pkg::CMD_INSERT: begin
                     res_in.pos  = done_tok.target;
                     res_in.used = done_tok.used + CW'(1);
                  end
                  uat_pkg::CMD_DELETE: begin
                     if (done_tok.found) begin
                        res_in.pos  = done_tok.pos;
                        res_in.used = done_tok.used - CW'(1);
                     end else begin
                        res_in.status = uat_pkg::ST_NOT_FOUND;
                     end
                  end
                  uat_pkg::CMD_REPLACE: begin
                     res_in.count = done_tok.count;
                     if (done_tok.count == '0) res_in.status = uat_pkg::ST_NOT_FOUND;
                  end
                  uat_pkg::CMD_READ: begin
                     res_in.rdata = done_tok.rdata;
                  end
                  default: begin
                  end
               endcase
               used_in  = res_in.used;
               state_in = uat_pkg::FSM_OUT;
            end
         end
         uat_pkg::FSM_OUT: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = uat_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = uat_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff        <= uat_pkg::FSM_IDLE;
         launch_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         used_ff         <= '0;
         capacity_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         if (csr_wr_en) capacity_ff <= csr_wr_data;
      end
   end

   assign launch_tok     = launch_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_position   = rsp_ff.pos[5:0];
   assign rsp_used_count = rsp_ff.used[6:0];
   assign rsp_read_data  = rsp_ff.rdata;
   assign rsp_replaced   = rsp_ff.count[6:0];

endmodule

`default_nettype wire

### rtl/unsorted_array_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    cmd, value, new_value, read_index
// rsp_      out        rsp_valid/stall    status, position, used_count, read_data, replaced
// csr_      in         csr_wr_en          capacity (csr_wr_data)
//
// Insert, delete, replace and in-range read walk the row of DEPTH cells one
// cell a cycle, then the FSM registers the result and moves it to the output
// register. Clear, failed insert, out-of-range read and unused codes skip the
// row and go straight to the output register. The next request is taken once
// the result sits in the output register, which holds under rsp_stall; a
// stalled result delays the next one. Synchronous reset empties the list and
// zeroes capacity; entries keep whatever they held.

module unsorted_array_table #(
   parameter int DEPTH = uat_pkg::DEPTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [2:0]          req_cmd,
   input  wire  signed [31:0]  req_value,
   input  wire  signed [31:0]  req_new_value,
   input  wire  [5:0]          req_read_index,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [5:0]          rsp_position,
   output logic [6:0]          rsp_used_count,
   output logic signed [31:0]  rsp_read_data,
   output logic [6:0]          rsp_replaced,
   input  wire                 csr_wr_en,
   input  wire  [6:0]          csr_wr_data
);

   uat_pkg::token_type tok [DEPTH+1];
   logic signed [31:0] ent [DEPTH];
   logic               shift [DEPTH];

   uat_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_new_value  (req_new_value),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_used_count (rsp_used_count),
      .rsp_read_data  (rsp_read_data),
      .rsp_replaced   (rsp_replaced),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .launch_tok     (tok[0]),
      .done_tok       (tok[DEPTH])
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] nxt_entry;
      logic               nxt_shift;
      if (i == DEPTH - 1) begin : g_last
         assign nxt_entry = '0;
         assign nxt_shift = 1'b0;
      end else begin : g_mid
         assign nxt_entry = ent[i+1];
         assign nxt_shift = shift[i+1];
      end
      uat_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1]),
         .next_entry (nxt_entry),
         .next_shift (nxt_shift),
         .entry_out  (ent[i]),
         .shift_out  (shift[i])
      );
   end

endmodule

`default_nettype wire

### tb/unsorted_array_table_tb.sv
`timescale 1ns / 1ps

module unsorted_array_table_tb;

   localparam int ROWS = uat_pkg::DEPTH_DEFAULT;

   typedef struct {
      uat_pkg::status_type status;
      logic [5:0]          position;
      logic [6:0]          used_count;
      logic signed [31:0]  read_data;
      logic [6:0]          replaced;
   } outcome_type;

   // Tracks the list contents and predicts one response per accepted request.
   class list_tracker;
      logic signed [31:0] store [ROWS];
      int unsigned        fill;
      logic [6:0]         capacity;
      outcome_type        expected_rsp [$];
      int                 fail_count;

      function new();
         fill = 0;
         capacity = '0;
         fail_count = 0;
      endfunction

      function void note_request(logic [2:0] cmd, logic signed [31:0] value,
                                 logic signed [31:0] new_value, logic [5:0] read_index);
         outcome_type o;
         int unsigned limit;
         int          hit;
         int          n;
         o.status = uat_pkg::ST_OK;
         o.position = '0;
         o.read_data = '0;
         o.replaced = '0;
         limit = (capacity > ROWS) ? ROWS : capacity;
         hit = -1;
         n = 0;
         case (cmd)
            uat_pkg::CMD_INSERT: begin
               if (fill < limit) begin
                  store[fill] = value;
                  o.position = 6'(fill);
                  fill++;
               end else begin
                  o.status = uat_pkg::ST_FULL;
               end
            end
            uat_pkg::CMD_DELETE: begin
               for (int i = 0; i < fill; i++)
                  if (hit < 0 && store[i] == value) hit = i;
               if (hit >= 0) begin
                  // close the gap left by the removed entry
                  for (int i = hit; i + 1 < fill; i++) store[i] = store[i + 1];
                  fill--;
                  o.position = 6'(hit);
               end else begin
                  o.status = uat_pkg::ST_NOT_FOUND;
               end
            end
            uat_pkg::CMD_REPLACE: begin
               for (int i = 0; i < fill; i++)
                  if (store[i] == value) begin
                     store[i] = new_value;
                     n++;
                  end
               o.replaced = 7'(n);
               if (n == 0) o.status = uat_pkg::ST_NOT_FOUND;
            end
            uat_pkg::CMD_READ: begin
               if (read_index < fill) o.read_data = store[read_index];
               else o.status = uat_pkg::ST_BAD_INDEX;
            end
            uat_pkg::CMD_CLEAR: fill = 0;
            default: ;
         endcase
         o.used_count = 7'(fill);
         expected_rsp.push_back(o);
      endfunction

      function void flag(string what);
         fail_count++;
         if (fail_count <= 10) $display("%t mismatch: %s", $realtime, what);
      endfunction

      function void check_response(logic [1:0] status, logic [5:0] position,
                                   logic [6:0] used_count, logic signed [31:0] read_data,
                                   logic [6:0] replaced);
         outcome_type o;
         if (expected_rsp.size() == 0) begin
            flag("response with no request outstanding");
            return;
         end
         o = expected_rsp.pop_front();
         if (status !== o.status || position !== o.position ||
             used_count !== o.used_count || read_data !== o.read_data ||
             replaced !== o.replaced)
            flag($sformatf({"exp status %0d pos %0d used %0d data %0h repl %0d, ",
                            "got status %0d pos %0d used %0d data %0h repl %0d"},
                           o.status, o.position, o.used_count, o.read_data, o.replaced,
                           status, position, used_count, read_data, replaced));
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_cmd;
   logic signed [31:0] req_value;
   logic signed [31:0] req_new_value;
   logic [5:0]         req_read_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [5:0]         rsp_position;
   logic [6:0]         rsp_used_count;
   logic signed [31:0] rsp_read_data;
   logic [6:0]         rsp_replaced;
   logic               csr_wr_en;
   logic [6:0]         csr_wr_data;

   list_tracker        tracker;
   logic signed [31:0] pool [8];
   int                 burst_left;
   bit                 pressure_go;

   unsorted_array_table i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_new_value  (req_new_value),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_used_count (rsp_used_count),
      .rsp_read_data  (rsp_read_data),
      .rsp_replaced   (rsp_replaced),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_status, rsp_position, rsp_used_count,
                                rsp_read_data, rsp_replaced);
   end

   // Receiver: stall on a pattern that changes every run, with one long hold-off.
   initial begin
      int  mode;
      int  run;
      bit  held;
      rsp_stall = 1'b0;
      held = 1'b0;
      forever begin
         if (pressure_go && !held) begin
            held = 1'b1;
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (800) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         run = $urandom_range(10, 150);
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= ($urandom_range(0, 3) < mode);
         end
      end
   end

   initial begin
      #8_000_000;
      $display("[unsorted_array_table] ERROR");
      $finish;
   end

   task automatic issue(logic [2:0] cmd, logic signed [31:0] value,
                        logic signed [31:0] new_value, logic [5:0] read_index);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_value <= value;
      req_new_value <= new_value;
      req_read_index <= read_index;
      do @(posedge clock); while (req_stall);
      tracker.note_request(cmd, value, new_value, read_index);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.expected_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(logic [6:0] cap);
      csr_wr_data <= cap;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.capacity = cap;
   endtask

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return pool[$urandom_range(0, 7)];
      if (r < 9) return $urandom_range(0, 15);
      return $urandom;
   endfunction

   task automatic run_random(int count, int ins_pct, int clr_pct);
      int         r;
      logic [2:0] cmd;
      logic [5:0] idx;
      pool[0] = 0;
      pool[1] = -1;
      pool[2] = 32'h8000_0000;
      pool[3] = 32'h7fff_ffff;
      for (int i = 4; i < 8; i++) pool[i] = $urandom;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < ins_pct) cmd = uat_pkg::CMD_INSERT;
         else if (r < ins_pct + clr_pct) cmd = uat_pkg::CMD_CLEAR;
         else if (r >= 98) cmd = 3'($urandom_range(5, 7));
         else begin
            // split the rest over delete, replace and read
            case ($urandom_range(0, 2))
               0: cmd = uat_pkg::CMD_DELETE;
               1: cmd = uat_pkg::CMD_REPLACE;
               default: cmd = uat_pkg::CMD_READ;
            endcase
         end
         if (tracker.fill > 0 && $urandom_range(0, 3) != 0)
            idx = 6'($urandom_range(0, tracker.fill - 1));
         else
            idx = 6'($urandom_range(0, 63));
         issue(cmd, pick_value(), pick_value(), idx);
      end
      wait_idle();
   endtask

   initial begin
      int          caps   [8];
      int          counts [8];
      int          ins    [8];
      int          clr    [8];
      tracker = new();
      pressure_go = 1'b0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0;
      req_value = '0;
      req_new_value = '0;
      req_read_index = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // list not created yet: insert reports full, the rest act on an empty list
      write_capacity(7'd0);
      issue(uat_pkg::CMD_INSERT, 5, 0, 6'd0);
      issue(uat_pkg::CMD_READ, 0, 0, 6'd0);
      issue(uat_pkg::CMD_DELETE, 5, 0, 6'd0);
      issue(uat_pkg::CMD_REPLACE, 5, 6, 6'd0);
      issue(3'd5, 1, 1, 6'd1);
      issue(3'd7, -1, -1, 6'd63);
      issue(uat_pkg::CMD_CLEAR, 0, 0, 6'd0);
      wait_idle();

      // two-entry list: full insert, replace on a full list, adjacent deletes
      write_capacity(7'd2);
      issue(uat_pkg::CMD_INSERT, 32'h8000_0000, 0, 6'd0);
      issue(uat_pkg::CMD_INSERT, 32'h7fff_ffff, 0, 6'd0);
      issue(uat_pkg::CMD_INSERT, 0, 0, 6'd0);
      issue(uat_pkg::CMD_READ, 0, 0, 6'd1);
      issue(uat_pkg::CMD_READ, 0, 0, 6'd63);
      issue(uat_pkg::CMD_REPLACE, 32'h7fff_ffff, 32'h8000_0000, 6'd0);
      issue(uat_pkg::CMD_REPLACE, 32'h8000_0000, -1, 6'd0);
      issue(uat_pkg::CMD_DELETE, -1, 0, 6'd0);
      issue(uat_pkg::CMD_DELETE, -1, 0, 6'd0);
      issue(uat_pkg::CMD_DELETE, -1, 0, 6'd0);
      wait_idle();

      // capacity above the store size saturates
      write_capacity(7'd127);
      issue(uat_pkg::CMD_INSERT, -1, 0, 6'd0);
      issue(uat_pkg::CMD_INSERT, 0, 0, 6'd0);
      issue(uat_pkg::CMD_INSERT, -1, 0, 6'd0);
      wait_idle();

      // capacity lowered below the fill: entries stay and inserts fail; after a clear only one fits
      write_capacity(7'd1);
      issue(uat_pkg::CMD_INSERT, 7, 0, 6'd0);
      issue(uat_pkg::CMD_READ, 0, 0, 6'd2);
      issue(uat_pkg::CMD_DELETE, 0, 0, 6'd0);
      issue(uat_pkg::CMD_CLEAR, 0, 0, 6'd0);
      issue(uat_pkg::CMD_INSERT, 7, 0, 6'd0);
      issue(uat_pkg::CMD_INSERT, 8, 0, 6'd0);
      wait_idle();

      caps   = '{64, 127, 3, 0, 1, 64, 0, 127};
      counts = '{300, 250, 150, 100, 150, 400, 300, 200};
      ins    = '{60, 40, 30, 30, 40, 55, 45, 35};
      clr    = '{0, 2, 0, 2, 5, 1, 3, 2};
      caps[6] = $urandom_range(2, 63);
      pressure_go = 1'b1;
      for (int p = 0; p < 8; p++) begin
         write_capacity(7'(caps[p]));
         run_random(counts[p], ins[p], clr[p]);
      end

      repeat (ROWS + 8) @(negedge clock);
      if (tracker.expected_rsp.size() != 0) tracker.flag("responses still outstanding");
      if (tracker.fail_count == 0)
         $display("[unsorted_array_table] OK");
      else
         $display("[unsorted_array_table] ERROR");
      $finish;
   end

endmodule
